// ===== rtl/bgi_pkg.sv =====
// Shared constants and types for the bicubic grid interpolator.
// Used by every module in the rtl folder; depends on nothing.
`default_nettype none

package bgi_pkg;

    // Grid and store geometry.
    localparam int GRID_SIDE       = 64;
    localparam int COL_W           = $clog2(GRID_SIDE);
    localparam int MAX_CHANNELS    = 8;
    localparam int CH_W            = $clog2(MAX_CHANNELS);
    localparam int ADDR_W          = 2 * COL_W + CH_W;
    localparam int SAMP_W          = 16;

    // Configuration registers.
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 7;
    localparam int GSIZE_W         = 7;
    localparam int NCH_W           = 4;

    // Coordinate and kernel formats.
    localparam int COORD_FRAC_BITS = 8;
    localparam int COORD_W         = 16;
    localparam int WEIGHT_FRAC     = 14;
    localparam int T_W             = COORD_FRAC_BITS + 1;
    localparam int T2_W            = 2 * T_W;
    localparam int T3_W            = 3 * T_W;
    localparam int NUM_W           = 3 * COORD_FRAC_BITS + 8;
    localparam int RND_SHIFT       = 3 * COORD_FRAC_BITS + 1 - WEIGHT_FRAC;
    localparam int WT_W            = 18;
    localparam int SUM_W           = 20;

    // Accumulator and divider widths.
    localparam int A_W             = 36;
    localparam int R_W             = 36;
    localparam int HALF_W          = R_W / 2;
    localparam int ACC_W           = 57;
    localparam int DIV_NW          = 58;
    localparam int DIV_DW          = SUM_W + 1;

    // Register indexes and commands.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 2'd1;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;

endpackage

`default_nettype wire

// ===== rtl/bgi_sample_ram.sv =====
// Single-port synchronous sample store with a registered read.
// Depends on bgi_pkg for its address and data widths.
`default_nettype none

module bgi_sample_ram (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire bgi_pkg::t_addr         i_addr,
    input  wire logic [bgi_pkg::SAMP_W-1:0] i_wdata,
    output logic [bgi_pkg::SAMP_W-1:0]  o_rdata
);
    import bgi_pkg::*;

    logic [SAMP_W-1:0] r_mem [2**ADDR_W];

    // Write or read one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bgi_div.sv =====
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
// Depends on bgi_pkg for the operand widths.
`default_nettype none

module bgi_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bgi_pkg::DIV_NW-1:0] i_numer,
    input  wire logic [bgi_pkg::DIV_DW-1:0] i_denom,
    output logic                            o_done,
    output logic [bgi_pkg::DIV_NW-1:0]      o_quot
);
    import bgi_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_DW:0]  r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]  rem_sh;
    logic             fits;

    // Shift in the next numerator bit and try the subtraction.
    always_comb begin
        rem_sh = {r_rem[DIV_DW-1:0], o_quot[DIV_NW-1]};
        fits   = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW - 1);
                r_rem  <= '0;
                r_den  <= i_denom;
                o_quot <= i_numer;
            end else if (r_busy) begin
                r_rem  <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
                o_quot <= {o_quot[DIV_NW-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bicubic_grid_interpolator.sv =====
// Top level of the bicubic grid interpolator: control sequencer and datapath.
// Depends on bgi_pkg, bgi_sample_ram and bgi_div.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   command, write and query fields
//  out      output     o_out_valid / i_out_ready channel, value, in_range, last
//  cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// A sample write goes straight to the store. A query computes eight kernel
// weights, then per channel sixteen store reads, five divisions on the single
// bit-serial divider, the partial products and one output. A point outside
// the grid skips all of these and gives a zero value for each channel.
// Reset is synchronous; it clears control, configuration and output valid only.
// One query is in work at a time; a full output register stalls the sequencer.
`default_nettype none

module bicubic_grid_interpolator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bgi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bgi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_command,
    input  wire logic [5:0]                      i_write_col,
    input  wire logic [5:0]                      i_write_row,
    input  wire logic [2:0]                      i_write_channel,
    input  wire logic signed [15:0]              i_write_value,
    input  wire logic signed [15:0]              i_query_x,
    input  wire logic signed [15:0]              i_query_y,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [2:0]                           o_out_channel,
    output logic signed [15:0]                   o_result_value,
    output logic                                 o_in_range,
    output logic                                 o_last
);
    import bgi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_W1, S_W2, S_W3, S_W4, S_RD, S_MUL, S_ACC,
        S_DS, S_DW, S_MX1, S_MX2, S_MX3, S_OUT
    } t_state;

    t_state r_state;

    logic [GSIZE_W-1:0] r_grid_size;
    logic [NCH_W-1:0]   r_nch;

    // Query registers.
    logic [COORD_W-2:0] r_x, r_y;
    logic               r_inside;
    logic [COL_W-1:0]   r_ix [4];
    logic [COL_W-1:0]   r_iy [4];
    logic signed [WT_W-1:0] r_w [8];
    logic signed [SUM_W-1:0] r_sy, r_sx;

    // Kernel weight datapath.
    logic [2:0]         r_k;
    logic [T_W-1:0]     r_t;
    logic               r_tzero;
    logic [T2_W-1:0]    r_t2;
    logic [T3_W-1:0]    r_t3;

    // Pass datapath.
    logic [1:0]         r_i, r_j;
    logic [CH_W-1:0]    r_c;
    logic               r_xpass;
    logic signed [WT_W+SAMP_W-1:0] r_prod;
    logic signed [A_W-1:0]   r_a;
    logic signed [R_W-1:0]   r_r;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [WT_W+HALF_W:0] r_pp;
    logic signed [SAMP_W-1:0] r_val;

    logic               in_fire;
    logic [SAMP_W-1:0]  ram_rdata;
    t_addr              ram_addr;
    logic               ram_we;
    logic               div_start, div_done;
    logic [DIV_NW-1:0]  div_numer, div_quot;
    logic [DIV_DW-1:0]  div_denom;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign ram_we     = in_fire && (i_command == CMD_WRITE);
    assign ram_addr   = ram_we ? {i_write_col, i_write_row, i_write_channel}
                               : {r_ix[r_i], r_iy[r_j], r_c};

    bgi_sample_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_write_value),
        .o_rdata (ram_rdata)
    );

    // Neighbor indices and range check for the incoming point.
    logic [GSIZE_W-1:0] dim_m1;
    logic [COORD_W-1:0] limit;
    logic               q_inside;
    logic [COL_W-1:0]   nx [4];
    logic [COL_W-1:0]   ny [4];

    function automatic logic [COL_W-1:0] clamp_hi(input logic [GSIZE_W-1:0] v,
                                                  input logic [GSIZE_W-1:0] m);
        return (v < m) ? v[COL_W-1:0] : m[COL_W-1:0];
    endfunction

    always_comb begin
        logic [COL_W-1:0] bx, by;
        dim_m1   = r_grid_size - 1'b1;
        limit    = {1'b0, r_grid_size, 8'd0};
        q_inside = !i_query_x[COORD_W-1] && !i_query_y[COORD_W-1]
                   && ({1'b0, i_query_x[COORD_W-2:0]} < limit)
                   && ({1'b0, i_query_y[COORD_W-2:0]} < limit);
        bx = i_query_x[COL_W+COORD_FRAC_BITS-1:COORD_FRAC_BITS];
        by = i_query_y[COL_W+COORD_FRAC_BITS-1:COORD_FRAC_BITS];
        nx[0] = (bx != '0) ? bx - 1'b1 : '0;
        nx[1] = bx;
        nx[2] = clamp_hi({1'b0, bx} + 7'd1, dim_m1);
        nx[3] = clamp_hi({1'b0, bx} + 7'd2, dim_m1);
        ny[0] = (by != '0) ? by - 1'b1 : '0;
        ny[1] = by;
        ny[2] = clamp_hi({1'b0, by} + 7'd1, dim_m1);
        ny[3] = clamp_hi({1'b0, by} + 7'd2, dim_m1);
    end

    // Distance from the sample to the point for weight k.
    logic signed [COORD_W-1:0] diff;
    logic [COORD_W-1:0]        dist_abs;
    logic signed [NUM_W-1:0]   knum;
    logic signed [NUM_W-1:0]   krnd;
    always_comb begin
        logic [COL_W-1:0]   idx;
        logic [COORD_W-2:0] crd;
        idx      = r_k[2] ? r_ix[r_k[1:0]] : r_iy[r_k[1:0]];
        crd      = r_k[2] ? r_x : r_y;
        diff     = $signed({1'b0, idx, 8'd0, 1'b0} >> 1) - $signed({1'b0, crd});
        dist_abs = diff[COORD_W-1] ? COORD_W'(-diff) : COORD_W'(diff);
        // Keys kernel numerator, inner and outer lobe.
        if (r_t <= T_W'(1 << COORD_FRAC_BITS)) begin
            knum = NUM_W'(1 << (3 * COORD_FRAC_BITS + 1))
                 - NUM_W'(5 * (1 << COORD_FRAC_BITS)) * $signed({1'b0, r_t2})
                 + NUM_W'(3) * $signed({1'b0, r_t3});
        end else begin
            knum = NUM_W'(1 << (3 * COORD_FRAC_BITS + 2))
                 - ($signed({1'b0, r_t}) <<< (2 * COORD_FRAC_BITS + 3))
                 + NUM_W'(5 * (1 << COORD_FRAC_BITS)) * $signed({1'b0, r_t2})
                 - $signed({1'b0, r_t3});
        end
        krnd = (knum + NUM_W'(1 << (RND_SHIFT - 1))) >>> RND_SHIFT;
    end

    // Divider operands: rounding to nearest via (2|n| + d) / 2d.
    logic signed [WT_W-1:0] wsel;
    always_comb begin
        logic [ACC_W-1:0] mag;
        logic signed [SUM_W-1:0] den;
        den = r_xpass ? r_sx : r_sy;
        if (r_xpass) begin
            mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        end else begin
            mag = ACC_W'(r_a[A_W-1] ? -r_a : r_a);
        end
        div_numer = {mag, 1'b0} + DIV_NW'($unsigned(den));
        div_denom = {den, 1'b0};
        wsel      = (r_state == S_MUL) ? r_w[{1'b0, r_j}] : r_w[{1'b1, r_i}];
    end

    assign div_start = (r_state == S_DS);

    bgi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (div_numer),
        .i_denom (div_denom),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Signed quotient results and the saturated final value.
    logic signed [R_W-1:0]    r_next;
    logic signed [SAMP_W-1:0] v_sat;
    always_comb begin
        if (r_sy <= 0) begin
            r_next = '0;
        end else begin
            r_next = r_a[A_W-1] ? -$signed(div_quot[R_W-1:0])
                                : $signed(div_quot[R_W-1:0]);
        end
        if (r_sx <= 0) begin
            v_sat = '0;
        end else if (r_acc[ACC_W-1]) begin
            v_sat = (div_quot > DIV_NW'(32768)) ? 16'sh8000 : -$signed(div_quot[15:0]);
        end else begin
            v_sat = (div_quot > DIV_NW'(32767)) ? 16'sh7FFF : $signed(div_quot[15:0]);
        end
    end

    // Sequencer with configuration and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grid_size <= GSIZE_W'(GRID_SIDE);
            r_nch       <= NCH_W'(MAX_CHANNELS);
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_GRID_SIZE: begin
                        if (i_cfg_data == '0) r_grid_size <= GSIZE_W'(1);
                        else if (i_cfg_data > GSIZE_W'(GRID_SIDE))
                            r_grid_size <= GSIZE_W'(GRID_SIDE);
                        else r_grid_size <= i_cfg_data;
                    end
                    REG_CHANNELS: begin
                        if (i_cfg_data[NCH_W-1:0] == '0) r_nch <= NCH_W'(1);
                        else if (i_cfg_data[NCH_W-1:0] > NCH_W'(MAX_CHANNELS))
                            r_nch <= NCH_W'(MAX_CHANNELS);
                        else r_nch <= i_cfg_data[NCH_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && i_command == CMD_QUERY) begin
                        r_x      <= i_query_x[COORD_W-2:0];
                        r_y      <= i_query_y[COORD_W-2:0];
                        r_inside <= q_inside;
                        r_ix     <= nx;
                        r_iy     <= ny;
                        r_k      <= '0;
                        r_c      <= '0;
                        r_sy     <= '0;
                        r_sx     <= '0;
                        r_val    <= '0;
                        r_state  <= q_inside ? S_W1 : S_OUT;
                    end
                end
                S_W1: begin
                    r_t     <= dist_abs[T_W-1:0];
                    r_tzero <= dist_abs >= COORD_W'(2 << COORD_FRAC_BITS);
                    r_state <= S_W2;
                end
                S_W2: begin
                    r_t2    <= r_t * r_t;
                    r_state <= S_W3;
                end
                S_W3: begin
                    r_t3    <= r_t2 * T3_W'(r_t);
                    r_state <= S_W4;
                end
                S_W4: begin
                    r_w[r_k] <= r_tzero ? '0 : krnd[WT_W-1:0];
                    if (!r_tzero) begin
                        if (r_k[2]) r_sx <= r_sx + SUM_W'($signed(krnd[WT_W-1:0]));
                        else        r_sy <= r_sy + SUM_W'($signed(krnd[WT_W-1:0]));
                    end
                    r_k     <= r_k + 1'b1;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_a     <= '0;
                    r_acc   <= '0;
                    r_xpass <= 1'b0;
                    r_state <= (r_k == 3'd7) ? S_RD : S_W1;
                end
                S_RD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= wsel * $signed(ram_rdata);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_a     <= r_a + A_W'(r_prod);
                    r_j     <= r_j + 1'b1;
                    r_state <= (r_j == 2'd3) ? S_DS : S_RD;
                end
                S_DS: begin
                    r_state <= S_DW;
                end
                S_DW: begin
                    if (div_done) begin
                        if (r_xpass) begin
                            r_val   <= v_sat;
                            r_state <= S_OUT;
                        end else begin
                            r_r     <= r_next;
                            r_state <= S_MX1;
                        end
                    end
                end
                // Weight times pass value in two half-width partial products.
                S_MX1: begin
                    r_pp    <= wsel * $signed({1'b0, r_r[HALF_W-1:0]});
                    r_state <= S_MX2;
                end
                S_MX2: begin
                    r_acc   <= r_acc + ACC_W'(r_pp);
                    r_pp    <= (WT_W+HALF_W+1)'(wsel * $signed(r_r[R_W-1:HALF_W]));
                    r_state <= S_MX3;
                end
                S_MX3: begin
                    r_acc   <= r_acc + (ACC_W'(r_pp) <<< HALF_W);
                    r_a     <= '0;
                    r_i     <= r_i + 1'b1;
                    if (r_i == 2'd3) begin
                        r_xpass <= 1'b1;
                        r_state <= S_DS;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid    <= 1'b1;
                        o_out_channel  <= 3'(r_c);
                        o_result_value <= r_val;
                        o_in_range     <= r_inside;
                        o_last         <= ({1'b0, r_c} == r_nch - 1'b1);
                        r_c            <= r_c + 1'b1;
                        r_i            <= '0;
                        r_j            <= '0;
                        r_a            <= '0;
                        r_acc          <= '0;
                        r_xpass        <= 1'b0;
                        if ({1'b0, r_c} == r_nch - 1'b1) r_state <= S_IDLE;
                        else r_state <= r_inside ? S_RD : S_OUT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
